// ===== src/emd_pkg.sv =====
`default_nettype none

package emd_pkg;

    // store geometry and scan window
    localparam int STORE_DEPTH = 64;
    localparam int WRAPS       = 4;
    localparam int HALF_WINDOW = 16;
    localparam int LAG_MARGIN  = 20;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int WRAP_W  = (WRAPS > 1) ? $clog2(WRAPS) : 1;
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int K_W     = $clog2(WIN_LEN + 1);
    localparam int NUM_WIN = 3;
    localparam int WIN_W   = 2;
    localparam int SUM_W   = ADDR_W + 3;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int TV_W     = 14;
    localparam int POS_W    = 9;
    localparam int THR_W    = 11;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

    // scan counter marks
    localparam logic [K_W-1:0]   K_CENTER = K_W'(HALF_WINDOW);
    localparam logic [K_W-1:0]   K_LAST   = K_W'(WIN_LEN - 1);
    localparam logic [WIN_W-1:0] WIN_MID  = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(NUM_WIN - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             wr;
        logic             rd;
        logic             first;
        logic             center;
        logic             last;
        logic [WIN_W-1:0] win;
        logic             decide;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/emd_in_if.sv =====
`default_nettype none

interface emd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [emd_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== src/emd_out_if.sv =====
`default_nettype none

interface emd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [emd_pkg::TV_W-1:0]       transform_value;
    logic signed [emd_pkg::SAMPLE_W-1:0]   raw_sample;
    logic [emd_pkg::POS_W-1:0]             position;
    logic                                  is_max;

    modport source (output valid, output transform_value, output raw_sample,
                    output position, output is_max, input ready);
    modport sink   (input valid, input transform_value, input raw_sample,
                    input position, input is_max, output ready);
endinterface

`default_nettype wire

// ===== src/ecg_morph_extremum_detector_unit.sv =====
`default_nettype none

// ECG extremum detector: each accepted item writes one 12-bit sample into a
// 64-entry circular store (valid bits cleared at reset), then the block evaluates the
// morphological transform (max + min - 2x) * 10 / 16 over 33-entry windows at
// three consecutive positions behind the newest sample and reports the middle
// one when it is a local maximum or minimum (or the end of a plateau) whose
// magnitude exceeds the threshold register (byte address 0, reset 5). A new
// item is taken only after the previous one has passed through the write,
// the window reads through the store's single read port, the drain of the
// read pipeline and the decision. The decision waits while a previous
// result is still held in the output register. No clearing pass is needed
// after reset.
module ecg_morph_extremum_detector_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    emd_in_if.sink                              samples,
    emd_out_if.source                           extrema,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [emd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [emd_pkg::THR_W-1:0]     threshold_reg, threshold_next;
    logic [emd_pkg::REG_IDX_W-1:0] reg_idx;
    emd_pkg::cmd_t                 cmd;
    emd_pkg::status_t              status;

    // register port decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[emd_pkg::PADDR_W-1:2];

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && (reg_idx == emd_pkg::REG_THRESHOLD))
        begin
            threshold_next = pwdata[emd_pkg::THR_W-1:0];
        end
        prdata = '0;
        if (reg_idx == emd_pkg::REG_THRESHOLD)
        begin
            prdata = 32'(threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= emd_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // sequencer
    emd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store, transform and decision
    emd_datapath u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .sample              (samples.sample),
        .threshold           (threshold_reg),
        .out_valid           (extrema.valid),
        .out_ready           (extrema.ready),
        .out_transform_value (extrema.transform_value),
        .out_raw_sample      (extrema.raw_sample),
        .out_position        (extrema.position),
        .out_is_max          (extrema.is_max)
    );

endmodule

`default_nettype wire

// ===== src/emd_ctrl.sv =====
`default_nettype none

module emd_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire emd_pkg::status_t  status,
    output emd_pkg::cmd_t          cmd
);

    emd_pkg::state_t              state_reg, state_next;
    logic [emd_pkg::K_W-1:0]      k_reg, k_next;
    logic [emd_pkg::WIN_W-1:0]    win_reg, win_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        win_next   = win_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            emd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr     = 1'b1;
                    k_next     = '0;
                    win_next   = '0;
                    state_next = emd_pkg::ST_SCAN;
                end
            end
            emd_pkg::ST_SCAN:
            begin
                cmd.rd     = 1'b1;
                cmd.first  = (k_reg == '0);
                cmd.center = (k_reg == emd_pkg::K_CENTER);
                cmd.last   = (k_reg == emd_pkg::K_LAST);
                cmd.win    = win_reg;
                if (k_reg == emd_pkg::K_LAST)
                begin
                    k_next = '0;
                    if (win_reg == emd_pkg::WIN_LAST)
                    begin
                        state_next = emd_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        win_next = win_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            emd_pkg::ST_DRAIN:
            begin
                state_next = emd_pkg::ST_DECIDE;
            end
            emd_pkg::ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = emd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = emd_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emd_pkg::ST_IDLE;
            k_reg     <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            win_reg   <= win_next;
        end
    end

`ifndef ASSERT_OFF
    // a new item always starts the scan from the first entry of the first window
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |=> (state_reg == emd_pkg::ST_SCAN) && (k_reg == '0) && (win_reg == '0))
        else $error("scan did not start cleanly after accept");

    // a decision is only taken when the output register can hold it
    a_decide_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> status.out_free)
        else $error("decision with output register busy");

    // the scan ends after the last entry of the last window
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emd_pkg::ST_SCAN) && (k_reg == emd_pkg::K_LAST) &&
        (win_reg == emd_pkg::WIN_LAST) |=> (state_reg == emd_pkg::ST_DRAIN))
        else $error("scan did not end after last window");
`endif

endmodule

`default_nettype wire

// ===== src/emd_datapath.sv =====
`default_nettype none

module emd_datapath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire emd_pkg::cmd_t                        cmd,
    output emd_pkg::status_t                          status,
    input  wire logic signed [emd_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [emd_pkg::THR_W-1:0]            threshold,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [emd_pkg::TV_W-1:0]           out_transform_value,
    output logic signed [emd_pkg::SAMPLE_W-1:0]       out_raw_sample,
    output logic [emd_pkg::POS_W-1:0]                 out_position,
    output logic                                      out_is_max
);

    localparam int D = emd_pkg::STORE_DEPTH;

    // sample store with one valid bit per entry
    logic signed [emd_pkg::SAMPLE_W-1:0] store_mem [D];
    logic [D-1:0]                        valid_reg;
    logic signed [emd_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                                rd_valid_reg;

    logic [emd_pkg::ADDR_W-1:0]          wi_reg, wi_next;
    logic [emd_pkg::ADDR_W-1:0]          b_reg, b_next;
    logic [emd_pkg::WRAP_W-1:0]          wrap_reg, wrap_next;
    logic [emd_pkg::WRAP_W:0]            wrap_inc;
    logic signed [emd_pkg::TV_W-1:0]     plateau_reg, plateau_next;

    // scan pipeline
    logic [emd_pkg::K_W-1:0]             k_run_reg;
    logic [emd_pkg::K_W-1:0]             k_off;
    logic [emd_pkg::SUM_W-1:0]           addr_sum;
    logic [emd_pkg::ADDR_W-1:0]          rd_addr;
    logic                                first_d_reg, center_d_reg, last_d_reg;
    logic [emd_pkg::WIN_W-1:0]           win_d_reg;
    logic signed [emd_pkg::SAMPLE_W-1:0] d, hi_cur, lo_cur, hi_new, lo_new, x_new;
    logic signed [emd_pkg::SAMPLE_W-1:0] hi_reg, lo_reg, ctr_reg, raw_reg;
    logic signed [14:0]                  diff;
    logic signed [17:0]                  scaled;
    logic signed [emd_pkg::TV_W-1:0]     tv;
    logic signed [emd_pkg::TV_W-1:0]     t_reg [emd_pkg::NUM_WIN];

    // decision
    logic signed [emd_pkg::TV_W-1:0]     t0, t1, t2;
    logic [emd_pkg::TV_W-1:0]            mag1;
    logic                                big, smax, smin, pmax, pmin, emit, is_max;
    logic [emd_pkg::ADDR_W-1:0]          mid_idx;
    logic [emd_pkg::POS_W-1:0]           pos;
    logic                                out_valid_reg, out_valid_next;

    // write pointer, probe base and wrap counter for the new item
    always_comb
    begin
        wi_next   = emd_pkg::ADDR_W'((emd_pkg::SUM_W'(wi_reg) + 1'b1) % D);
        b_next    = emd_pkg::ADDR_W'((emd_pkg::SUM_W'(wi_next) + 1'b1 +
                    emd_pkg::SUM_W'(emd_pkg::LAG_MARGIN)) % D);
        wrap_inc  = (emd_pkg::WRAP_W+1)'(wrap_reg) + 1'b1;
        wrap_next = wrap_reg;
        if (b_next == '0)
        begin
            wrap_next = (wrap_inc >= (emd_pkg::WRAP_W+1)'(emd_pkg::WRAPS)) ?
                        '0 : emd_pkg::WRAP_W'(wrap_inc);
        end
    end

    // scan offset within the current window
    assign k_off = cmd.first ? '0 : k_run_reg;

    // read address: window base plus scan offset
    assign addr_sum = emd_pkg::SUM_W'(b_reg) + emd_pkg::SUM_W'(cmd.win) +
                      emd_pkg::SUM_W'(D - (emd_pkg::HALF_WINDOW % D)) +
                      emd_pkg::SUM_W'(k_off);
    assign rd_addr  = emd_pkg::ADDR_W'(addr_sum % D);

    // local scan offset mirrors the controller count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_run_reg <= '0;
        end
        else if (cmd.rd)
        begin
            k_run_reg <= cmd.last ? '0 : (cmd.first ? emd_pkg::K_W'(1) : k_run_reg + 1'b1);
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            store_mem[wi_reg] <= sample;
        end
        if (cmd.rd)
        begin
            rd_data_reg  <= store_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // window max, min and center value
    always_comb
    begin
        d      = rd_valid_reg ? rd_data_reg : '0;
        hi_cur = first_d_reg ? '0 : hi_reg;
        lo_cur = first_d_reg ? '0 : lo_reg;
        hi_new = (d > hi_cur) ? d : hi_cur;
        lo_new = (d < lo_cur) ? d : lo_cur;
        x_new  = center_d_reg ? d : ctr_reg;
        diff   = 15'(hi_new) + 15'(lo_new) - (15'(x_new) <<< 1);
        scaled = (18'(diff) <<< 3) + (18'(diff) <<< 1);
        tv     = emd_pkg::TV_W'(scaled >>> 4);
    end

    // extremum test over the three transform values
    always_comb
    begin
        t0      = t_reg[0];
        t1      = t_reg[1];
        t2      = t_reg[2];
        mag1    = t1[emd_pkg::TV_W-1] ? emd_pkg::TV_W'(-t1) : t1;
        big     = mag1 > emd_pkg::TV_W'(threshold);
        smax    = (t1 > t2) && (t1 > t0);
        smin    = (t1 < t2) && (t1 < t0);
        pmax    = (plateau_reg < t1) && (t1 > t2);
        pmin    = (plateau_reg > t1) && (t1 < t2);
        emit    = big && (smax || smin || ((t1 == t0) && (pmax || pmin)));
        is_max  = (smax || smin) ? smax : pmax;
        plateau_next = ((t1 == t2) && (t1 != t0) && big) ? t0 : plateau_reg;
        mid_idx = emd_pkg::ADDR_W'((emd_pkg::SUM_W'(b_reg) + 1'b1) % D);
        if (mid_idx != '0)
        begin
            pos = emd_pkg::POS_W'(mid_idx) +
                  emd_pkg::POS_W'(D) * emd_pkg::POS_W'(wrap_reg);
        end
        else
        begin
            pos = emd_pkg::POS_W'(D) * (emd_pkg::POS_W'(wrap_reg) + 1'b1);
        end
    end

    // output register handshake
    always_comb
    begin
        status.out_free = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.decide && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wi_reg        <= '0;
            b_reg         <= '0;
            wrap_reg      <= '0;
            plateau_reg   <= '0;
            first_d_reg   <= 1'b0;
            center_d_reg  <= 1'b0;
            last_d_reg    <= 1'b0;
            win_d_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                valid_reg[wi_reg] <= 1'b1;
                wi_reg            <= wi_next;
                b_reg             <= b_next;
                wrap_reg          <= wrap_next;
            end
            if (cmd.decide)
            begin
                plateau_reg <= plateau_next;
            end
            first_d_reg   <= cmd.rd && cmd.first;
            center_d_reg  <= cmd.rd && cmd.center;
            last_d_reg    <= cmd.rd && cmd.last;
            win_d_reg     <= cmd.win;
            out_valid_reg <= out_valid_next;
        end
    end

    // scan accumulators and result payload
    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_new;
        lo_reg  <= lo_new;
        ctr_reg <= x_new;
        if (center_d_reg && (win_d_reg == emd_pkg::WIN_MID))
        begin
            raw_reg <= d;
        end
        if (last_d_reg)
        begin
            t_reg[win_d_reg] <= tv;
        end
        if (cmd.decide && emit)
        begin
            out_transform_value <= t1;
            out_raw_sample      <= raw_reg;
            out_position        <= pos;
            out_is_max          <= is_max;
        end
    end

`ifndef ASSERT_OFF
    // a result only appears as the outcome of a decision
    a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.decide))
        else $error("result appeared without a decision");
`endif

endmodule

`default_nettype wire
